FILE: design/dis_pkg.sv
`default_nettype none

package dis_pkg;

  // Field widths and positions on the streaming buses.
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 8;
  localparam int VEC_W       = 64;
  localparam int CFG_W       = 9;
  localparam int EDGE_W      = 2 * IDX_W;

  localparam int IN_CMD_LO   = 0;
  localparam int IN_NODE_LO  = IN_CMD_LO + CMD_W;
  localparam int IN_PRED_LO  = IN_NODE_LO + IDX_W;
  localparam int IN_VEC_LO   = IN_PRED_LO + IDX_W;
  localparam int IN_ESC_LO   = IN_VEC_LO + VEC_W;
  localparam int IN_TDATA_W  = 152;

  localparam int OUT_TDATA_W = 136;

  // Register reset values.
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd1;
  localparam logic [CFG_W-1:0] CATCHER_RST    = 9'd257;

  // Configuration register indexes.
  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_CATCHER    = 1'b1
  } cfg_idx_t;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_EDGE,
    S_INIT,
    S_NRD,
    S_NWR,
    S_ERD,
    S_EPRED,
    S_ENODE,
    S_EWR,
    S_QRD,
    S_QDO,
    S_RESP
  } state_t;

  // Per-field write enables of the node store.
  typedef struct packed {
    logic gen;
    logic out;
    logic inn;
  } node_wen_t;

endpackage

`default_nettype wire

FILE: design/dis_node_store.sv
`default_nettype none

module dis_node_store import dis_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int VAR_BITS  = 64
) (
  input  wire logic                         clk,
  input  wire node_wen_t                    wen,
  input  wire logic [$clog2(MAX_NODES)-1:0] waddr,
  input  wire logic [VAR_BITS-1:0]          wr_in,
  input  wire logic [VAR_BITS-1:0]          wr_out,
  input  wire logic [VAR_BITS-1:0]          wr_gen,
  input  wire logic [$clog2(MAX_NODES)-1:0] raddr,
  output logic      [VAR_BITS-1:0]          rd_in,
  output logic      [VAR_BITS-1:0]          rd_out,
  output logic      [VAR_BITS-1:0]          rd_gen
);

  // One word per node: gen, OUT and IN sets side by side, each with its own lane enable.
  logic [3*VAR_BITS-1:0] mem [MAX_NODES];
  logic [3*VAR_BITS-1:0] rdata_r;

  // Lane writes.
  always_ff @(posedge clk) begin
    if (wen.inn) begin
      mem[waddr][0 +: VAR_BITS] <= wr_in;
    end
    if (wen.out) begin
      mem[waddr][VAR_BITS +: VAR_BITS] <= wr_out;
    end
    if (wen.gen) begin
      mem[waddr][2*VAR_BITS +: VAR_BITS] <= wr_gen;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rd_in  = rdata_r[0 +: VAR_BITS];
  assign rd_out = rdata_r[VAR_BITS +: VAR_BITS];
  assign rd_gen = rdata_r[2*VAR_BITS +: VAR_BITS];

endmodule

`default_nettype wire

FILE: design/dis_edge_store.sv
`default_nettype none

module dis_edge_store import dis_pkg::*; #(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire logic [EDGE_W-1:0]              push_data,
  output logic                                full,
  output logic      [$clog2(MAX_EDGES+1)-1:0] total,
  input  wire logic [$clog2(MAX_EDGES)-1:0]   raddr,
  output logic      [EDGE_W-1:0]              rdata
);

  localparam int EW = $clog2(MAX_EDGES + 1);

  logic [EDGE_W-1:0] mem [MAX_EDGES];
  logic [EW-1:0]     total_r;
  logic [EW-1:0]     total_nxt;
  logic [EDGE_W-1:0] rdata_r;

  assign full = (total_r == EW'(MAX_EDGES));

  // Edges are appended in arrival order; a push into a full store is dropped.
  always_comb begin
    total_nxt = total_r;
    if (push && !full) begin
      total_nxt = total_r + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Append write and registered read.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[total_r[$clog2(MAX_EDGES)-1:0]] <= push_data;
    end
    rdata_r <= mem[raddr];
  end

  assign total = total_r;
  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/definite_init_dataflow_solver_unit.sv
`default_nettype none

// Channel  | Direction | Handshake                | Contents
// in_      | input     | in_tvalid / in_tready    | cmd, node_index, pred_index, bit_vector,
//          |           |                          | escaped_mask
// out_     | output    | out_tvalid / out_tready  | in_set, uninit_mask, edge_overflow, done_res
// cfg_     | input     | cfg_we                   | node_count (0), catcher_index (1)
//
// A load or edge word passes S_LOAD or S_EDGE, a query S_QRD and S_QDO, before S_RESP moves
// its result into the free output register; the next word is accepted back in S_IDLE.
// A solve first initialises every used node (S_INIT), then each sweep passes the nodes (S_NRD,
// S_NWR), reads every stored edge (S_ERD, S_EPRED), relaxes each edge between used nodes
// (S_ENODE, S_EWR) and closes in S_ERD; sweeps repeat until nothing changes.
// After reset a clearing pass over all MAX_NODES entries sets the IN and OUT sets to all ones
// and gen to zero; no word is accepted meanwhile. One word is worked on at a time; a finished
// result waits in the output register while the next word is taken.

module definite_init_dataflow_solver_unit import dis_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int VAR_BITS  = 64,
  parameter int MAX_EDGES = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // cmd[1:0], node_index[9:2], pred_index[17:10], bit_vector[81:18], escaped_mask[145:82]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // in_set[63:0], uninit_mask[127:64], edge_overflow[128], done_res[129]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]    ncount_r, catcher_r;
  logic [NCW-1:0]      act_n;
  logic [NCW-1:0]      idx_r;
  logic [EW-1:0]       e_r;
  logic                changed_r;

  logic [IDX_W-1:0]    node_r, pred_r;
  logic [VAR_BITS-1:0] vec_r, esc_r;
  logic [EDGE_W-1:0]   ed_r;
  logic [VAR_BITS-1:0] opr_r;

  logic [VAR_BITS-1:0] res_in_r, res_un_r;
  logic                res_ovf_r, res_done_r;
  logic                out_valid_r;
  logic [VEC_W-1:0]    out_in_r, out_un_r;
  logic                out_ovf_r, out_done_r;

  node_wen_t           n_wen;
  logic [NW-1:0]       n_waddr, n_raddr;
  logic [VAR_BITS-1:0] n_wr_in, n_wr_out, n_wr_gen;
  logic [VAR_BITS-1:0] n_rd_in, n_rd_out, n_rd_gen;

  logic                e_push, e_full;
  logic [EW-1:0]       e_total;
  logic [EDGE_W-1:0]   e_rdata;

  logic                accept;
  logic                idx_last;
  logic                edge_live, node_live, query_chk, slot_free;
  logic [VAR_BITS-1:0] new_in, new_out, node_out, full_vec;

  assign full_vec = {VAR_BITS{1'b1}};
  assign accept   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Nodes in use: zero counts as one, and the count is capped at the store depth.
  always_comb begin
    if (ncount_r == '0) begin
      act_n = NCW'(1);
    end else if (32'(ncount_r) > MAX_NODES) begin
      act_n = NCW'(MAX_NODES);
    end else begin
      act_n = NCW'(ncount_r);
    end
  end

  assign idx_last  = (idx_r == act_n - NCW'(1));
  assign edge_live = (32'(e_rdata[EDGE_W-1:IDX_W]) < 32'(act_n)) &&
                     (32'(e_rdata[IDX_W-1:0]) < 32'(act_n));
  assign node_live = (32'(node_r) < MAX_NODES);
  assign query_chk = (32'(node_r) < 32'(act_n)) && ({1'b0, node_r} < catcher_r);

  // Transfer functions of one edge relaxation and one node pass.
  assign new_in   = n_rd_in & opr_r;
  assign new_out  = new_in | n_rd_gen;
  assign node_out = n_rd_in | n_rd_gen;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r  <= NODE_COUNT_RST;
      catcher_r <= CATCHER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_NODE_COUNT: ncount_r  <= cfg_wdata;
        CFG_CATCHER:    catcher_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (idx_r == NCW'(MAX_NODES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_tdata[IN_CMD_LO +: CMD_W]))
            CMD_LOAD:  state_nxt = S_LOAD;
            CMD_EDGE:  state_nxt = S_EDGE;
            CMD_SOLVE: state_nxt = S_INIT;
            CMD_QUERY: state_nxt = S_QRD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:  state_nxt = S_RESP;
      S_EDGE:  state_nxt = S_RESP;
      S_INIT:  if (idx_last) state_nxt = S_NRD;
      S_NRD:   state_nxt = S_NWR;
      S_NWR:   state_nxt = idx_last ? S_ERD : S_NRD;
      S_ERD: begin
        if (e_r == e_total) begin
          state_nxt = changed_r ? S_NRD : S_RESP;
        end else begin
          state_nxt = S_EPRED;
        end
      end
      S_EPRED: state_nxt = edge_live ? S_ENODE : S_ERD;
      S_ENODE: state_nxt = S_EWR;
      S_EWR:   state_nxt = S_ERD;
      S_QRD:   state_nxt = S_QDO;
      S_QDO:   state_nxt = S_RESP;
      S_RESP:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Store controls.
  always_comb begin
    in_tready = 1'b0;
    n_wen     = '0;
    n_waddr   = idx_r[NW-1:0];
    n_raddr   = idx_r[NW-1:0];
    n_wr_in   = full_vec;
    n_wr_out  = full_vec;
    n_wr_gen  = '0;
    e_push    = 1'b0;
    unique case (state_r)
      S_CLEAR: n_wen = '{gen: 1'b1, out: 1'b1, inn: 1'b1};
      S_IDLE:  in_tready = 1'b1;
      S_LOAD: begin
        n_wen.gen = node_live;
        n_waddr   = NW'(node_r);
        n_wr_gen  = vec_r;
      end
      S_EDGE:  e_push = 1'b1;
      S_INIT: begin
        n_wen   = '{gen: 1'b0, out: 1'b1, inn: 1'b1};
        n_wr_in = (idx_r == '0) ? '0 : full_vec;
      end
      S_NWR: begin
        n_wen.out = 1'b1;
        n_wr_out  = node_out;
      end
      S_EPRED: n_raddr = NW'(e_rdata[IDX_W-1:0]);
      S_ENODE: n_raddr = NW'(ed_r[EDGE_W-1:IDX_W]);
      S_EWR: begin
        n_wen    = '{gen: 1'b0, out: 1'b1, inn: 1'b1};
        n_waddr  = NW'(ed_r[EDGE_W-1:IDX_W]);
        n_wr_in  = new_in;
        n_wr_out = new_out;
      end
      S_QRD:   n_raddr = NW'(node_r);
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      e_r         <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_CLEAR: idx_r <= idx_r + NCW'(1);
        S_IDLE:  idx_r <= '0;
        S_INIT: begin
          idx_r     <= idx_last ? '0 : idx_r + NCW'(1);
          changed_r <= 1'b0;
        end
        S_NWR: begin
          if (node_out != n_rd_out) changed_r <= 1'b1;
          idx_r <= idx_last ? '0 : idx_r + NCW'(1);
          e_r   <= '0;
        end
        S_ERD: begin
          if (e_r == e_total) changed_r <= 1'b0;
        end
        S_EPRED: if (!edge_live) e_r <= e_r + EW'(1);
        S_EWR: begin
          if ((new_in != n_rd_in) || (new_out != n_rd_out)) changed_r <= 1'b1;
          e_r <= e_r + EW'(1);
        end
        default: ;
      endcase
      if (state_r == S_RESP && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Word and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      node_r     <= in_tdata[IN_NODE_LO +: IDX_W];
      pred_r     <= in_tdata[IN_PRED_LO +: IDX_W];
      vec_r      <= in_tdata[IN_VEC_LO +: VAR_BITS];
      esc_r      <= in_tdata[IN_ESC_LO +: VAR_BITS];
      res_in_r   <= '0;
      res_un_r   <= '0;
      res_ovf_r  <= 1'b0;
      res_done_r <= 1'b0;
    end
    if (state_r == S_EDGE) res_ovf_r <= e_full;
    if (state_r == S_ERD && e_r == e_total && !changed_r) res_done_r <= 1'b1;
    if (state_r == S_EPRED) ed_r <= e_rdata;
    if (state_r == S_ENODE) opr_r <= n_rd_out;
    if (state_r == S_QDO && node_live) begin
      res_in_r <= n_rd_in;
      res_un_r <= query_chk ? (vec_r & ~esc_r & ~n_rd_in) : '0;
    end
    if (state_r == S_RESP && slot_free) begin
      out_in_r   <= VEC_W'(res_in_r);
      out_un_r   <= VEC_W'(res_un_r);
      out_ovf_r  <= res_ovf_r;
      out_done_r <= res_done_r;
    end
  end

  dis_node_store #(
    .MAX_NODES (MAX_NODES),
    .VAR_BITS  (VAR_BITS)
  ) u_node (
    .clk    (clk),
    .wen    (n_wen),
    .waddr  (n_waddr),
    .wr_in  (n_wr_in),
    .wr_out (n_wr_out),
    .wr_gen (n_wr_gen),
    .raddr  (n_raddr),
    .rd_in  (n_rd_in),
    .rd_out (n_rd_out),
    .rd_gen (n_rd_gen)
  );

  dis_edge_store #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (e_push),
    .push_data ({node_r, pred_r}),
    .full      (e_full),
    .total     (e_total),
    .raddr     (e_r[EAW-1:0]),
    .rdata     (e_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_done_r, out_ovf_r, out_un_r, out_in_r};

  // The node store is left alone between words.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (n_wen == '0))
    else $error("node store written while idle");

  // No word is taken during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("word accepted during clearing pass");

  // Only edges between used nodes are relaxed.
  a_edge_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EWR) |->
      ((32'(ed_r[EDGE_W-1:IDX_W]) < 32'(act_n)) && (32'(ed_r[IDX_W-1:0]) < 32'(act_n))))
    else $error("relaxed an edge outside the used nodes");

endmodule

`default_nettype wire
